/* rtl/core/gflt_pkg.sv */
// Shared types and constants for the GF(2^W) log/antilog multiply-divide core.
package gflt_pkg;

    localparam int FIELD_BITS  = 8;
    localparam int DATA_BITS   = 8;
    localparam int POLY_BITS   = 9;
    localparam int FIELD_SIZE  = 1 << FIELD_BITS;
    localparam int FIELD_ORDER = FIELD_SIZE - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [FIELD_BITS-1:0] elem_t;
    typedef logic [FIELD_BITS:0]   elem_wide_t;
    typedef logic [POLY_BITS-1:0]  cfg_poly_t;
    typedef logic [DATA_BITS-1:0]  data_t;

    localparam cfg_poly_t  POLY_RESET    = cfg_poly_t'(285);
    localparam elem_wide_t ORDER_WIDE    = elem_wide_t'(FIELD_ORDER);
    localparam elem_t      LAST_STEP     = elem_t'(FIELD_ORDER - 1);
    localparam elem_t      FIELD_ONES    = elem_t'(FIELD_ORDER);

    localparam logic FUNC_MUL = 1'b0;
    localparam logic FUNC_DIV = 1'b1;

    typedef enum logic [1:0] {
        KIND_MUL,
        KIND_DIV,
        KIND_ZERO,
        KIND_DIV_ZERO
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        elem_t    left;
        elem_t    right;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_head_t;

    typedef struct packed {
        data_t value;
        logic  dbz;
    } result_t;

    typedef struct packed {
        elem_t log_addr_a;
        elem_t log_addr_b;
        elem_t alog_addr;
    } lookup_req_t;

    typedef struct packed {
        elem_t log_a;
        elem_t log_b;
        elem_t alog;
    } lookup_rsp_t;

endpackage

/* rtl/core/gflt_front.sv */
// Input side: accepts transactions, classifies them and holds them in a short queue.
module gflt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            func,
    input  gflt_pkg::data_t left_value,
    input  gflt_pkg::data_t right_value,
    input  logic            tables_ready,
    input  logic            head_pop,
    output gflt_pkg::op_head_t head
);
    import gflt_pkg::*;

    op_t                  queue_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 queue_full;
    logic                 do_push;
    logic                 do_pop;
    op_t                  op_in;
    elem_t                a_elem;
    elem_t                b_elem;

    assign a_elem = elem_t'(left_value);
    assign b_elem = elem_t'(right_value);

    always_comb
    begin
        op_in.left  = a_elem;
        op_in.right = b_elem;
        if (func == FUNC_MUL)
        begin
            op_in.kind = (a_elem == '0 || b_elem == '0) ? KIND_ZERO : KIND_MUL;
        end
        else if (a_elem == '0)
        begin
            op_in.kind = KIND_ZERO;
        end
        else if (b_elem == '0)
        begin
            op_in.kind = KIND_DIV_ZERO;
        end
        else
        begin
            op_in.kind = KIND_DIV;
        end
    end

    assign queue_full = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    // Held off while the tables are being built
    assign full       = queue_full || !tables_ready;
    assign do_push    = push && !full;
    assign head.valid = (count_reg != '0);
    assign head.op    = queue_mem[rd_ptr_reg];
    assign do_pop     = head_pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_mem[wr_ptr_reg] <= op_in;
        end
    end

endmodule

/* rtl/core/gflt_tables.sv */
// Log and antilog tables with the sequencer that builds them from the field polynomial.
module gflt_tables (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  gflt_pkg::cfg_poly_t   cfg_data,
    input  gflt_pkg::lookup_req_t req,
    output gflt_pkg::lookup_rsp_t rsp,
    output logic                  tables_ready
);
    import gflt_pkg::*;

    typedef enum logic {
        ST_BUILD,
        ST_READY
    } state_t;

    state_t                state_reg;
    cfg_poly_t             poly_reg;
    elem_t                 step_reg;
    elem_t                 elem_reg;
    elem_t                 elem_next;
    logic [FIELD_SIZE-1:0] log_vld_reg;
    elem_wide_t            poly_wide;
    elem_wide_t            shifted;

    elem_t                 log_mem  [FIELD_SIZE];
    elem_t                 alog_mem [FIELD_SIZE];
    elem_t                 log_a_reg;
    elem_t                 log_b_reg;
    logic                  vld_a_reg;
    logic                  vld_b_reg;
    elem_t                 alog_reg;

    assign poly_wide = elem_wide_t'(poly_reg);

    // One doubling step with reduction
    always_comb
    begin
        shifted = {elem_reg, 1'b0};
        if (shifted[FIELD_BITS])
        begin
            shifted = shifted ^ poly_wide;
        end
        elem_next = shifted[FIELD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_BUILD;
            poly_reg    <= POLY_RESET;
            step_reg    <= '0;
            elem_reg    <= elem_t'(1);
            log_vld_reg <= '0;
        end
        else if (cfg_write)
        begin
            state_reg   <= ST_BUILD;
            poly_reg    <= cfg_data;
            step_reg    <= '0;
            elem_reg    <= elem_t'(1);
            log_vld_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_BUILD:
                begin
                    log_vld_reg[elem_reg] <= 1'b1;
                    step_reg              <= step_reg + 1'b1;
                    elem_reg              <= elem_next;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_READY;
                    end
                end
                ST_READY:
                begin
                    state_reg <= ST_READY;
                end
                default:
                begin
                    state_reg <= ST_BUILD;
                end
            endcase
        end
    end

    assign tables_ready = (state_reg == ST_READY);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BUILD)
        begin
            log_mem[elem_reg]  <= step_reg;
            alog_mem[step_reg] <= elem_reg;
        end
        log_a_reg <= log_mem[req.log_addr_a];
        log_b_reg <= log_mem[req.log_addr_b];
        vld_a_reg <= log_vld_reg[req.log_addr_a];
        vld_b_reg <= log_vld_reg[req.log_addr_b];
        alog_reg  <= alog_mem[req.alog_addr];
    end

    // Elements the build never reached have logarithm zero
    assign rsp.log_a = vld_a_reg ? log_a_reg : '0;
    assign rsp.log_b = vld_b_reg ? log_b_reg : '0;
    assign rsp.alog  = alog_reg;

endmodule

/* rtl/core/gflt_back.sv */
// Execution side: log lookups, modular add/subtract, antilog lookup and result queue.
module gflt_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gflt_pkg::op_head_t    head,
    output logic                  head_pop,
    output gflt_pkg::lookup_req_t req,
    input  gflt_pkg::lookup_rsp_t rsp,
    output logic                  empty,
    input  logic                  pop,
    output gflt_pkg::data_t       field_result,
    output logic                  divide_by_zero
);
    import gflt_pkg::*;

    logic                 v_s1_reg;
    logic                 v_s2_reg;
    op_kind_t             kind_s1_reg;
    op_kind_t             kind_s2_reg;
    logic [QCNT_BITS-1:0] in_flight;
    logic                 issue;

    elem_wide_t           sum_w;
    elem_wide_t           diff_w;
    result_t              res_s2;

    result_t              out_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_pop;

    // Issue only when the result queue has room for everything in flight
    assign in_flight = count_reg + QCNT_BITS'(v_s1_reg) + QCNT_BITS'(v_s2_reg);
    assign issue     = head.valid && (in_flight < QCNT_BITS'(QUEUE_DEPTH));
    assign head_pop  = issue;

    assign req.log_addr_a = head.op.left;
    assign req.log_addr_b = head.op.right;

    always_comb
    begin
        sum_w = {1'b0, rsp.log_a} + {1'b0, rsp.log_b};
        if (sum_w >= ORDER_WIDE)
        begin
            sum_w = sum_w - ORDER_WIDE;
        end
        if (rsp.log_a >= rsp.log_b)
        begin
            diff_w = {1'b0, rsp.log_a} - {1'b0, rsp.log_b};
        end
        else
        begin
            diff_w = {1'b0, rsp.log_a} + ORDER_WIDE - {1'b0, rsp.log_b};
        end
    end

    assign req.alog_addr = (kind_s1_reg == KIND_DIV) ? diff_w[FIELD_BITS-1:0]
                                                     : sum_w[FIELD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg <= 1'b0;
            v_s2_reg <= 1'b0;
        end
        else
        begin
            v_s1_reg <= issue;
            v_s2_reg <= v_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_s1_reg <= head.op.kind;
        kind_s2_reg <= kind_s1_reg;
    end

    always_comb
    begin
        case (kind_s2_reg) inside
            KIND_MUL, KIND_DIV:
            begin
                res_s2.value = data_t'(rsp.alog);
                res_s2.dbz   = 1'b0;
            end
            KIND_DIV_ZERO:
            begin
                res_s2.value = data_t'(FIELD_ONES);
                res_s2.dbz   = 1'b1;
            end
            default:
            begin
                res_s2.value = '0;
                res_s2.dbz   = 1'b0;
            end
        endcase
    end

    assign empty          = (count_reg == '0);
    assign field_result   = out_mem[rd_ptr_reg].value;
    assign divide_by_zero = out_mem[rd_ptr_reg].dbz;
    assign do_pop         = pop && !empty;

    always_comb
    begin
        wr_ptr_next = v_s2_reg ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (v_s2_reg && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !v_s2_reg)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_s2_reg)
        begin
            out_mem[wr_ptr_reg] <= res_s2;
        end
    end

endmodule

/* rtl/core/gf2w_log_table_mul_div_core.sv */
// GF(2^8) multiply/divide core using log and antilog tables built from a programmable polynomial.
// After reset, and after every write of field_polynomial, the table builder fills one table
// entry per cycle with full held high; the default polynomial is 0x11D. Once built, one
// transaction is accepted per cycle while full is low, and the block sustains one result
// per cycle while pop is held high. A transaction passes a four-entry input queue, a
// registered log read, the modular add or subtract, a registered antilog read and a
// four-entry result queue. The result queue's free space limits issue, so pop may stall
// without losing anything. Multiply or divide with a zero left operand, or multiply with
// a zero right operand, gives zero; a nonzero value divided by zero gives all ones with
// divide_by_zero set. The polynomial must only be written while no transactions are
// outstanding.
module gf2w_log_table_mul_div_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                func,
    input  gflt_pkg::data_t     left_value,
    input  gflt_pkg::data_t     right_value,
    output logic                empty,
    input  logic                pop,
    output gflt_pkg::data_t     field_result,
    output logic                divide_by_zero,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  gflt_pkg::cfg_poly_t field_polynomial
);
    import gflt_pkg::*;

    op_head_t    head;
    logic        head_pop;
    lookup_req_t req;
    lookup_rsp_t rsp;
    logic        tables_ready;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    gflt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .left_value   (left_value),
        .right_value  (right_value),
        .tables_ready (tables_ready),
        .head_pop     (head_pop),
        .head         (head)
    );

    gflt_tables u_tables (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (field_polynomial),
        .req          (req),
        .rsp          (rsp),
        .tables_ready (tables_ready)
    );

    gflt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_pop       (head_pop),
        .req            (req),
        .rsp            (rsp),
        .empty          (empty),
        .pop            (pop),
        .field_result   (field_result),
        .divide_by_zero (divide_by_zero)
    );

endmodule

/* rtl/core/gflt_checker.sv */
// Port-level checks for the GF(2^W) multiply-divide core, bound to the top level.
module gflt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input gflt_pkg::data_t     field_result,
    input logic                divide_by_zero,
    input logic                cfg_valid,
    input logic                cfg_ready
);
    import gflt_pkg::*;

    // A polynomial write starts a rebuild, so input must be held off next cycle
    a_rebuild_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> full)
        else $error("input not held off after polynomial write");

    // Division by zero always reports the all-ones element
    a_dbz_value: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && divide_by_zero |-> field_result == data_t'(FIELD_ONES))
        else $error("divide_by_zero without all-ones result");

    // A waiting result is not withdrawn or altered while not popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(field_result) && $stable(divide_by_zero))
        else $error("waiting result changed before pop");

    // An empty output must stay empty when full held off input in each of the checked past cycles
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(full) && $past(full, 2) && $past(full, 3) && $past(empty) |-> empty)
        else $error("result appeared with no transaction accepted");

endmodule

bind gf2w_log_table_mul_div_core gflt_checker u_checker (.*);

/* tb/sv/tb_gf2w_log_table_mul_div_core.sv */
// Self-checking testbench for the GF(2^8) log/antilog multiply-divide core.
`timescale 1ns / 1ps

module tb_gf2w_log_table_mul_div_core;

    import gflt_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    logic      func;
    data_t     left_value;
    data_t     right_value;
    logic      empty;
    logic      pop;
    data_t     field_result;
    logic      divide_by_zero;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_poly_t field_polynomial;

    // local copy of the field tables and the outstanding results
    elem_t   log_of   [FIELD_SIZE];
    elem_t   power_of [FIELD_SIZE];
    result_t pending_results[$];

    int send_idle_pct;
    int pop_stall_pct;
    int mismatch_count;

    gf2w_log_table_mul_div_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .left_value     (left_value),
        .right_value    (right_value),
        .empty          (empty),
        .pop            (pop),
        .field_result   (field_result),
        .divide_by_zero (divide_by_zero),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .field_polynomial (field_polynomial)
    );

    always #5 clk = ~clk;

    // Walk the powers of x, reducing by the polynomial; unreached elements keep log 0.
    function automatic void build_field_tables(cfg_poly_t poly);
        logic [FIELD_BITS:0] walk;
        walk = elem_wide_t'(1);
        for (int i = 0; i < FIELD_SIZE; i++)
        begin
            log_of[i]   = '0;
            power_of[i] = '0;
        end
        for (int k = 0; k < FIELD_ORDER; k++)
        begin
            log_of[walk[FIELD_BITS-1:0]] = elem_t'(k);
            power_of[k]                  = walk[FIELD_BITS-1:0];
            walk = walk << 1;
            if (walk[FIELD_BITS])
                walk = walk ^ poly;
            walk[FIELD_BITS] = 1'b0;
        end
    endfunction

    function automatic result_t predict_field_op(logic op, data_t a, data_t b);
        result_t             r;
        elem_t               ea;
        elem_t               eb;
        logic [FIELD_BITS:0] idx;
        ea      = elem_t'(a);
        eb      = elem_t'(b);
        r.value = '0;
        r.dbz   = 1'b0;
        if (op == FUNC_MUL)
        begin
            if (ea != '0 && eb != '0)
            begin
                idx = {1'b0, log_of[ea]} + {1'b0, log_of[eb]};
                if (idx >= ORDER_WIDE)
                    idx = idx - ORDER_WIDE;
                r.value = data_t'(power_of[idx[FIELD_BITS-1:0]]);
            end
        end
        else if (ea != '0)
        begin
            if (eb == '0)
            begin
                r.value = data_t'(FIELD_ONES);
                r.dbz   = 1'b1;
            end
            else
            begin
                if (log_of[ea] >= log_of[eb])
                    idx = {1'b0, log_of[ea]} - {1'b0, log_of[eb]};
                else
                    idx = {1'b0, log_of[ea]} + ORDER_WIDE - {1'b0, log_of[eb]};
                r.value = data_t'(power_of[idx[FIELD_BITS-1:0]]);
            end
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(logic op, data_t a, data_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push        = 1'b1;
        func        = op;
        left_value  = a;
        right_value = b;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(predict_field_op(op, a, b));
        @(negedge clk);
    endtask

    task automatic wait_until_idle();
        push = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_polynomial(cfg_poly_t poly);
        wait_until_idle();
        cfg_valid        = 1'b1;
        field_polynomial = poly;
        do
            @(posedge clk);
        while (!cfg_ready);
        build_field_tables(poly);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic data_t pick_operand();
        case ($urandom_range(9))
            0:       return '0;
            1:       return data_t'(1);
            2:       return '1;
            3:       return data_t'(1) << $urandom_range(DATA_BITS - 1);
            default: return data_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_ops(int count);
        for (int n = 0; n < count; n++)
            send_op(logic'($urandom_range(1)), pick_operand(), pick_operand());
    endtask

    // zero operands, divide by zero, identities and the extremes of both operands
    task automatic send_corner_set();
        send_op(FUNC_MUL, 8'h00, 8'h00);
        send_op(FUNC_MUL, 8'h00, 8'hFF);
        send_op(FUNC_MUL, 8'hFF, 8'h00);
        send_op(FUNC_MUL, 8'h01, 8'h01);
        send_op(FUNC_MUL, 8'hFF, 8'hFF);
        send_op(FUNC_MUL, 8'h02, 8'h80);
        send_op(FUNC_MUL, 8'h80, 8'h80);
        send_op(FUNC_MUL, 8'h53, 8'hCA);
        send_op(FUNC_DIV, 8'h00, 8'h00);
        send_op(FUNC_DIV, 8'h00, 8'h07);
        send_op(FUNC_DIV, 8'hFF, 8'h00);
        send_op(FUNC_DIV, 8'h01, 8'h00);
        send_op(FUNC_DIV, 8'hFF, 8'hFF);
        send_op(FUNC_DIV, 8'h01, 8'hFF);
        send_op(FUNC_DIV, 8'hC8, 8'h01);
        send_op(FUNC_DIV, 8'h02, 8'h03);
        send_op(FUNC_DIV, 8'h80, 8'h02);
        send_op(FUNC_DIV, 8'h01, 8'h02);
    endtask

    task automatic test_default_polynomial_corners();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_corner_set();
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_random_ops(120);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 71;
        pop_stall_pct = 0;
        send_random_ops(90);
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 0;
        pop_stall_pct = 71;
        send_random_ops(90);
    endtask

    task automatic test_light_idling_both();
        send_idle_pct = 9;
        pop_stall_pct = 9;
        send_random_ops(90);
    endtask

    // extremes of the degree-8 range, a non-primitive polynomial, another primitive, a random one, then default
    task automatic test_polynomial_sweep();
        cfg_poly_t polys[6];
        polys[0] = cfg_poly_t'(256);
        polys[1] = cfg_poly_t'(511);
        polys[2] = cfg_poly_t'(283);
        polys[3] = cfg_poly_t'(299);
        polys[4] = cfg_poly_t'($urandom_range(256, 511));
        polys[5] = POLY_RESET;
        send_idle_pct = 30;
        pop_stall_pct = 30;
        foreach (polys[p])
        begin
            write_polynomial(polys[p]);
            send_corner_set();
            send_random_ops(25);
        end
    endtask

    always @(negedge clk)
        pop = ($urandom_range(99) >= pop_stall_pct);

    always @(posedge clk)
    begin
        result_t want;
        if (pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: field_result %0h divide_by_zero %0b",
                       field_result, divide_by_zero);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (field_result !== want.value)
                begin
                    $error("field_result expected %0h actual %0h", want.value, field_result);
                    mismatch_count++;
                end
                if (divide_by_zero !== want.dbz)
                begin
                    $error("divide_by_zero expected %0b actual %0b", want.dbz, divide_by_zero);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        push             = 1'b0;
        func             = FUNC_MUL;
        left_value       = '0;
        right_value      = '0;
        cfg_valid        = 1'b0;
        field_polynomial = POLY_RESET;
        send_idle_pct    = 0;
        pop_stall_pct    = 0;
        mismatch_count   = 0;
        build_field_tables(POLY_RESET);
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_default_polynomial_corners();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_backpressure();
        test_light_idling_both();
        test_polynomial_sweep();

        wait_until_idle();
        repeat (12) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
